/* rtl/core/lpht_pkg.sv */
// Shared types and constants of the linear probing hash table.
package lpht_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CAP_W       = SLOT_W + 1;
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int MOD_DIGIT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_REPLACED  = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_DELETED   = 3'd4,
        RES_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

/* rtl/core/lpht_req_if.sv */
// Request, response and configuration channels of the hash table.
interface lpht_req_if;
    logic                        valid;
    logic                        ready;
    logic [lpht_pkg::CMD_W-1:0]  cmd;
    logic [lpht_pkg::KEY_W-1:0]  key;
    logic [lpht_pkg::HASH_W-1:0] key_hash;

    modport source (output valid, cmd, key, key_hash, input ready);
    modport sink   (input valid, cmd, key, key_hash, output ready);
endinterface

interface lpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::SLOT_W-1:0]   slot;
    logic [lpht_pkg::COUNT_W-1:0]  element_count;

    modport source (output valid, status, slot, element_count, input ready);
    modport sink   (input valid, status, slot, element_count, output ready);
endinterface

interface lpht_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lpht_pkg::CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/linear_probe_hash_table_core.sv */
// Top level: open-addressing hash table with linear probing over slot memories.
//
//  channel  dir  payload                           completes when
//  i_req    in   cmd, key, key_hash                valid & ready
//  o_rsp    out  status, slot, element_count       valid & ready
//  i_cfg    in   data = capacity in use (9 bits)   valid & ready (ready always high)
//
//  One request at a time. Each request is accepted, then the hash remainder
//  is formed (8 steps of 4 bits in lpht_mod, then handed over), then one slot
//  is probed after another, then the result is handed off; a bad command
//  skips the remainder and probing.
//  The probe loop runs at one slot per cycle off the registered-read slot RAMs.
//  After reset a clearing sweep marks all 256 slots empty (i_req not ready
//  meanwhile); config writes are taken throughout.
//  A held result in o_rsp only stalls the handoff of the next one.
module linear_probe_hash_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp,
    lpht_cfg_if.sink   i_cfg
);
    import lpht_pkg::*;

    // state / control
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [CAP_W-1:0]  r_cap;           // effective capacity, 1..SLOTS
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SLOT_W-1:0] r_pos, n_pos;    // slot whose data arrives this cycle
    logic [SLOT_W-1:0] r_cnt, n_cnt;    // probes done for this request
    logic [COUNT_W-1:0] r_count, n_count;
    t_status           r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [COUNT_W-1:0] r_out_count;
    logic               out_load;

    // slot memories
    logic [1:0]        st_mem  [SLOTS];
    logic [KEY_W-1:0]  key_mem [SLOTS];
    logic [1:0]        r_rd_st;
    logic [KEY_W-1:0]  r_rd_key;
    logic [SLOT_W-1:0] mem_ra, mem_wa;
    logic              st_we, key_we;
    t_slot_st          st_wd;

    // remainder unit
    logic              mod_start, mod_done;
    logic [SLOT_W-1:0] mod_rem;

    logic [SLOT_W-1:0] nxt_pos;
    logic              last_probe, req_fire, key_hit;
    t_slot_st          cur_st;

    lpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_req.key_hash),
        .i_divisor  (r_cap),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // wrap at the capacity in use
    assign nxt_pos    = (({1'b0, r_pos} + 1'b1) == r_cap) ? '0 : r_pos + 1'b1;
    assign last_probe = ({1'b0, r_cnt} == (r_cap - 1'b1));
    assign cur_st     = t_slot_st'(r_rd_st);
    assign key_hit    = (r_rd_key == r_key);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        mod_start    = 1'b0;
        st_we        = 1'b0;
        key_we       = 1'b0;
        st_wd        = SLOT_LIVE;
        mem_wa       = r_pos;
        mem_ra       = nxt_pos;         // speculative read of the next slot
        out_load     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                st_we  = 1'b1;
                st_wd  = SLOT_EMPTY;
                mem_wa = r_clr;
                n_clr  = r_clr + 1'b1;
                if (r_clr == SLOT_W'(SLOTS - 1))
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd = i_req.cmd;
                    n_key = i_req.key;
                    if (i_req.cmd == CMD_INSERT || i_req.cmd == CMD_SEARCH ||
                        i_req.cmd == CMD_DELETE) begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end else begin
                        // meaningless command: table untouched
                        n_res_status = RES_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    mem_ra  = mod_rem;
                    n_pos   = mod_rem;
                    n_cnt   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_pos = nxt_pos;
                n_cnt = r_cnt + 1'b1;
                if (r_cmd == CMD_INSERT) begin
                    if (cur_st != SLOT_LIVE) begin
                        // empty or tombstone: take it
                        st_we        = 1'b1;
                        key_we       = 1'b1;
                        st_wd        = SLOT_LIVE;
                        n_count      = r_count + 1'b1;
                        n_res_status = RES_INSERTED;
                        n_res_slot   = r_pos;
                        n_state      = S_DONE;
                    end else if (key_hit) begin
                        n_res_status = RES_REPLACED;
                        n_res_slot   = r_pos;
                        n_state      = S_DONE;
                    end else if (last_probe) begin
                        n_res_status = RES_FULL;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end
                end else begin
                    if (cur_st == SLOT_EMPTY) begin
                        n_res_status = RES_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else if (cur_st == SLOT_LIVE && key_hit) begin
                        n_res_slot = r_pos;
                        if (r_cmd == CMD_DELETE) begin
                            st_we        = 1'b1;
                            st_wd        = SLOT_TOMB;
                            n_count      = r_count - 1'b1;
                            n_res_status = RES_DELETED;
                        end else begin
                            n_res_status = RES_FOUND;
                        end
                        n_state = S_DONE;
                    end else if (last_probe) begin
                        n_res_status = RES_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_cap       <= CAP_W'(SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                // zero reads as one, above the slot count saturates
                if (i_cfg.data == '0)
                    r_cap <= CAP_W'(1);
                else if (i_cfg.data > CAP_W'(SLOTS))
                    r_cap <= CAP_W'(SLOTS);
                else
                    r_cap <= i_cfg.data;
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_rsp.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_count  <= r_count;
        end
    end

    // slot state RAM
    always_ff @(posedge i_clk) begin
        if (st_we)
            st_mem[mem_wa] <= st_wd;
        r_rd_st <= st_mem[mem_ra];
    end

    // key RAM
    always_ff @(posedge i_clk) begin
        if (key_we)
            key_mem[mem_wa] <= r_key;
        r_rd_key <= key_mem[mem_ra];
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.element_count = r_out_count;
endmodule

/* rtl/core/lpht_mod.sv */
// Iterative remainder of the key hash by the capacity, a few bits per cycle.
module lpht_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::HASH_W-1:0] i_dividend,
    input  logic [lpht_pkg::CAP_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [lpht_pkg::SLOT_W-1:0] o_rem
);
    import lpht_pkg::*;

    localparam int STEPS  = HASH_W / MOD_DIGIT_W;
    localparam int STEP_W = $clog2(STEPS);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [HASH_W-1:0] r_dvd;
    logic [CAP_W-1:0]  r_dvs;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [CAP_W-1:0]  part;

    // restoring remainder, one dividend bit per inner step
    always_comb begin
        n_rem = r_rem;
        part  = '0;
        for (int i = 0; i < MOD_DIGIT_W; i++) begin
            part = {n_rem, r_dvd[HASH_W-1-i]};
            if (part >= r_dvs)
                part = part - r_dvs;
            n_rem = part[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << MOD_DIGIT_W;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* rtl/core/lpht_checker.sv */
// Port-level checks of the hash table core, bound to the top level.
module lpht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [lpht_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [lpht_pkg::SLOT_W-1:0]   i_rsp_slot,
    input logic [lpht_pkg::COUNT_W-1:0]  i_rsp_count
);
    import lpht_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status))
        else $error("response dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == RES_NOT_FOUND || i_rsp_status == RES_FULL)
        |-> i_rsp_slot == '0)
        else $error("slot not zero on miss or full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_count <= COUNT_W'(SLOTS))
        else $error("element count above slot count");
endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_slot   (o_rsp.slot),
    .i_rsp_count  (o_rsp.element_count)
);
